// ===== hw/rtl/cce_pkg.sv =====
// Package for the cyclic code encoder and checker: payload types, the
// configuration struct, register and opcode codes and a mask helper.
// No dependencies; every other RTL file but cce_stream_if imports it.
`default_nettype none

package cce_pkg;

  localparam int unsigned WORD_W    = 64;  // codeword field width
  localparam int unsigned POLY_W    = 32;  // generator and syndrome width
  localparam int unsigned CFG_W     = 6;   // degree and length register width
  localparam int unsigned LEN_W     = 7;   // holds a bit count up to 64
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CRC_STEP  = 8;   // message bits folded per stage

  localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_DEGREE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LENGTH = 2'd2;

  localparam logic [POLY_W-1:0] RST_GEN_POLY_LOW   = 32'd3;
  localparam logic [CFG_W-1:0]  RST_CHECK_DEGREE   = 6'd3;
  localparam logic [CFG_W-1:0]  RST_MESSAGE_LENGTH = 6'd4;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [WORD_W-1:0] data_word;
    logic [WORD_W-1:0] error_pattern;
  } cce_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic [POLY_W-1:0] syndrome;
    logic              error_detected;
    logic              undetected_error;
  } cce_out_t;

  typedef struct packed {
    logic [POLY_W-1:0] gen_poly_low;
    logic [CFG_W-1:0]  check_degree;
    logic [CFG_W-1:0]  message_length;
  } cce_cfg_t;

  // Ones in the low 'bits' positions of a codeword-wide vector.
  function automatic logic [WORD_W-1:0] low_mask(input logic [LEN_W-1:0] bits);
    logic [WORD_W-1:0] m;
    if (bits >= LEN_W'(WORD_W)) begin
      m = '1;
    end else begin
      m = (WORD_W'(1) << bits) - WORD_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cce_stream_if.sv =====
// Valid/ready stream interface used for the input and result channels.
// The payload type is a parameter; no package dependency.
`default_nettype none

interface cce_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cce_prep.sv =====
// First pipeline stage: clamps the configuration, masks and splits the word
// into the part to be divided and the low check bits. Uses cce_pkg and
// cce_stream_if.
`default_nettype none

module cce_prep #(
  parameter int unsigned MAX_CHECK_BITS   = 32,
  parameter int unsigned MAX_MESSAGE_BITS = 32,
  localparam int unsigned R      = MAX_CHECK_BITS,
  localparam int unsigned K      = MAX_MESSAGE_BITS,
  localparam int unsigned R_W    = $clog2(R + 1),
  localparam int unsigned K_W    = $clog2(K + 1),
  localparam int unsigned NST    = (K + cce_pkg::CRC_STEP - 1) / cce_pkg::CRC_STEP,
  localparam int unsigned H_W    = NST * cce_pkg::CRC_STEP,
  localparam int unsigned SIDE_W = 2 + R_W + R + cce_pkg::WORD_W
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  cce_pkg::cce_cfg_t       cfg_i,
  cce_stream_if.sink              in_i,
  output logic                    valid_o,
  input  wire                     ready_i,
  output logic [H_W-1:0]          h_o,
  output logic [R-1:0]            gal_o,
  output logic [SIDE_W-1:0]       side_o
);
  import cce_pkg::*;

  logic [R_W-1:0]    r_eff;
  logic [K_W-1:0]    k_eff;
  logic [LEN_W-1:0]  r_ext, k_ext, n_ext;
  logic [WORD_W-1:0] mask_r, mask_k, mask_n;
  logic [WORD_W-1:0] msg, recv, recv_hi, recv_lo, err_m, code;
  logic [R-1:0]      poly_m, low;
  logic [K-1:0]      hval;
  logic              err_nz;

  logic              valid_q;
  logic [H_W-1:0]    h_q, h_d;
  logic [R-1:0]      gal_q, gal_d;
  logic [SIDE_W-1:0] side_q, side_d;
  logic              take;

  always_comb begin
    if (cfg_i.check_degree == '0) begin
      r_eff = R_W'(1);
    end else if (cfg_i.check_degree > CFG_W'(R)) begin
      r_eff = R_W'(R);
    end else begin
      r_eff = cfg_i.check_degree[R_W-1:0];
    end
    if (cfg_i.message_length == '0) begin
      k_eff = K_W'(1);
    end else if (cfg_i.message_length > CFG_W'(K)) begin
      k_eff = K_W'(K);
    end else begin
      k_eff = cfg_i.message_length[K_W-1:0];
    end
  end

  assign r_ext  = LEN_W'(r_eff);
  assign k_ext  = LEN_W'(k_eff);
  assign n_ext  = r_ext + k_ext;
  assign mask_r = low_mask(r_ext);
  assign mask_k = low_mask(k_ext);
  assign mask_n = low_mask(n_ext);

  assign msg     = in_i.payload.data_word & mask_k;
  assign err_m   = in_i.payload.error_pattern & mask_n;
  assign recv    = (in_i.payload.data_word & mask_n) ^ err_m;
  assign recv_hi = recv >> r_ext;
  assign recv_lo = recv & mask_r;
  assign err_nz  = |err_m;

  // The generator is aligned to the top of the remainder register so that
  // every stage can treat the degree as fixed.
  assign poly_m = cfg_i.gen_poly_low[R-1:0] & mask_r[R-1:0];
  assign gal_d  = poly_m << (R_W'(R) - r_eff);

  always_comb begin
    if (in_i.payload.opcode == OP_CHECK) begin
      code = recv;
      hval = recv_hi[K-1:0];
      low  = recv_lo[R-1:0];
    end else begin
      code = msg << r_ext;
      hval = msg[K-1:0];
      low  = '0;
    end
  end

  assign h_d    = H_W'(hval);
  assign side_d = {in_i.payload.opcode, err_nz, r_eff, low, code};

  assign in_i.ready = !valid_q || ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      h_q    <= h_d;
      gal_q  <= gal_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign h_o     = h_q;
  assign gal_o   = gal_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cce_crc_stage.sv =====
// One division stage: folds CRC_STEP message bits, MSB first, into the
// top-aligned remainder. Elastic register stage; uses cce_pkg.
`default_nettype none

module cce_crc_stage #(
  parameter int unsigned R      = 32,
  parameter int unsigned H_W    = 32,
  parameter int unsigned SIDE_W = 104
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               valid_i,
  output logic              ready_o,
  input  wire [R-1:0]       crc_i,
  input  wire [H_W-1:0]     h_i,
  input  wire [R-1:0]       gal_i,
  input  wire [SIDE_W-1:0]  side_i,
  output logic              valid_o,
  input  wire               ready_i,
  output logic [R-1:0]      crc_o,
  output logic [H_W-1:0]    h_o,
  output logic [R-1:0]      gal_o,
  output logic [SIDE_W-1:0] side_o
);
  import cce_pkg::*;

  logic [R-1:0]      crc_d, crc_q;
  logic [H_W-1:0]    h_q;
  logic [R-1:0]      gal_q;
  logic [SIDE_W-1:0] side_q;
  logic              valid_q;

  always_comb begin
    logic [R-1:0] c;
    logic         fb;
    c = crc_i;
    for (int j = 0; j < CRC_STEP; j++) begin
      fb = c[R-1] ^ h_i[H_W-1-j];
      c  = c << 1;
      if (fb) begin
        c = c ^ gal_i;
      end
    end
    crc_d = c;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      crc_q  <= crc_d;
      h_q    <= h_i << CRC_STEP;
      gal_q  <= gal_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign crc_o   = crc_q;
  assign h_o     = h_q;
  assign gal_o   = gal_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cce_finish.sv =====
// Last stage and result register: realigns the remainder, adds the low
// received bits, builds the codeword and flags. Uses cce_pkg, cce_stream_if.
`default_nettype none

module cce_finish #(
  parameter int unsigned R = 32,
  localparam int unsigned R_W    = $clog2(R + 1),
  localparam int unsigned SIDE_W = 2 + R_W + R + cce_pkg::WORD_W
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              valid_i,
  output logic             ready_o,
  input  wire [R-1:0]      crc_i,
  input  wire [SIDE_W-1:0] side_i,
  cce_stream_if.source     out_o
);
  import cce_pkg::*;

  logic [WORD_W-1:0] code_in;
  logic [R-1:0]      low, rem;
  logic [R_W-1:0]    r_in;
  logic              err_nz, op;
  cce_out_t          res_d, res_q;
  logic              op_q;
  logic [R_W-1:0]    r_q;
  logic              valid_q;

  assign code_in = side_i[WORD_W-1:0];
  assign low     = side_i[WORD_W +: R];
  assign r_in    = side_i[WORD_W+R +: R_W];
  assign err_nz  = side_i[SIDE_W-2];
  assign op      = side_i[SIDE_W-1];

  assign rem = (crc_i >> (R_W'(R) - r_in)) ^ low;

  always_comb begin
    res_d.syndrome = POLY_W'(rem);
    if (op == OP_CHECK) begin
      res_d.code_word        = code_in;
      res_d.error_detected   = |rem;
      res_d.undetected_error = err_nz && !(|rem);
    end else begin
      res_d.code_word        = code_in | WORD_W'(rem);
      res_d.error_detected   = 1'b0;
      res_d.undetected_error = 1'b0;
    end
  end

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
      op_q  <= op;
      r_q   <= r_in;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = res_q;

  a_encode_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && op_q == OP_ENCODE |-> !res_q.error_detected && !res_q.undetected_error)
    else $error("flags raised on an encoded item");

  a_detect_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && op_q == OP_CHECK |-> res_q.error_detected == (|res_q.syndrome))
    else $error("error_detected disagrees with syndrome");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(res_q.error_detected && res_q.undetected_error))
    else $error("both error flags set");

  a_parity_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && op_q == OP_ENCODE |->
      (res_q.code_word & low_mask(LEN_W'(r_q))) == WORD_W'(res_q.syndrome))
    else $error("codeword check bits differ from syndrome");

  a_syndrome_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (res_q.syndrome >> r_q) == '0)
    else $error("syndrome has bits at or above the degree");

endmodule

`default_nettype wire

// ===== hw/rtl/cyclic_code_encode_and_check.sv =====
// Systematic binary cyclic code encoder and syndrome checker. One item is
// accepted per clock cycle for as long as the result side keeps taking
// results; each item yields exactly one result. An item passes through an
// input preparation register, the division stages, each of which folds
// eight message bits, and the result register. Every stage is an elastic
// register with its own valid bit, so a stall at the output backs up
// through the pipeline without losing or repeating an item. Configuration
// (generator low coefficients, degree r and message length k) is written
// through the plain write port and must only change while no item is in
// flight; out-of-range degree and length are clamped to 1..MAX_CHECK_BITS
// and 1..MAX_MESSAGE_BITS.
// Depends on cce_pkg, cce_stream_if, cce_prep, cce_crc_stage, cce_finish.
`default_nettype none

module cyclic_code_encode_and_check #(
  parameter int unsigned MAX_CHECK_BITS   = 32,
  parameter int unsigned MAX_MESSAGE_BITS = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [cce_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [cce_pkg::POLY_W-1:0]        cfg_data_i,
  cce_stream_if.sink                       in_i,
  cce_stream_if.source                     out_o
);
  import cce_pkg::*;

  localparam int unsigned R      = MAX_CHECK_BITS;
  localparam int unsigned K      = MAX_MESSAGE_BITS;
  localparam int unsigned R_W    = $clog2(R + 1);
  localparam int unsigned NST    = (K + CRC_STEP - 1) / CRC_STEP;
  localparam int unsigned H_W    = NST * CRC_STEP;
  localparam int unsigned SIDE_W = 2 + R_W + R + WORD_W;

  // Configuration registers. Writes to an index beyond the list are dropped.
  cce_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gen_poly_low   <= RST_GEN_POLY_LOW;
      cfg_q.check_degree   <= RST_CHECK_DEGREE;
      cfg_q.message_length <= RST_MESSAGE_LENGTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GEN_POLY_LOW:   cfg_q.gen_poly_low   <= cfg_data_i;
        REG_CHECK_DEGREE:   cfg_q.check_degree   <= cfg_data_i[CFG_W-1:0];
        REG_MESSAGE_LENGTH: cfg_q.message_length <= cfg_data_i[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage signals: index s is the output of stage s, where stage 0 is the
  // preparation register and stage NST feeds the result register.
  logic              valid_s [NST+1];
  logic              ready_s [NST+1];
  logic [R-1:0]      crc_s   [NST+1];
  logic [H_W-1:0]    h_s     [NST+1];
  logic [R-1:0]      gal_s   [NST+1];
  logic [SIDE_W-1:0] side_s  [NST+1];

  // The division starts from an empty remainder.
  assign crc_s[0] = '0;

  cce_prep #(
    .MAX_CHECK_BITS   (R),
    .MAX_MESSAGE_BITS (K)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_i    (in_i),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .h_o     (h_s[0]),
    .gal_o   (gal_s[0]),
    .side_o  (side_s[0])
  );

  // The message part is taken MSB first; its leading zero padding leaves
  // the remainder at zero, so the fixed number of stages suits any length.
  for (genvar s = 0; s < NST; s++) begin : g_div
    cce_crc_stage #(
      .R      (R),
      .H_W    (H_W),
      .SIDE_W (SIDE_W)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[s]),
      .ready_o (ready_s[s]),
      .crc_i   (crc_s[s]),
      .h_i     (h_s[s]),
      .gal_i   (gal_s[s]),
      .side_i  (side_s[s]),
      .valid_o (valid_s[s+1]),
      .ready_i (ready_s[s+1]),
      .crc_o   (crc_s[s+1]),
      .h_o     (h_s[s+1]),
      .gal_o   (gal_s[s+1]),
      .side_o  (side_s[s+1])
    );
  end

  cce_finish #(
    .R (R)
  ) u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[NST]),
    .ready_o (ready_s[NST]),
    .crc_i   (crc_s[NST]),
    .side_i  (side_s[NST]),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/cyclic_code_encode_and_check_test.sv =====
// Self-checking testbench for cyclic_code_encode_and_check: encodes and checks
// random and hand-picked words under several generator settings.
// Depends on cce_pkg, cce_stream_if and the encoder/checker RTL.
`timescale 1ns / 100ps

module cyclic_code_encode_and_check_test;
  import cce_pkg::*;

  localparam int unsigned MAX_R       = 32;
  localparam int unsigned MAX_K       = 32;
  // Allowance for the preparation register, the division stages and the result register.
  localparam int unsigned LATENCY     = 6;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned N_PHASES    = 9;

  // Scoreboard: keeps its own copy of the generator settings, predicts the
  // codeword, syndrome and flags for every accepted item and compares them,
  // in order, with what the block returns.
  class codeword_scoreboard;
    logic [31:0] poly_low;
    logic [5:0]  degree_reg;
    logic [5:0]  length_reg;
    cce_out_t    outcome_q[$];
    int unsigned mismatches;

    function new();
      poly_low   = RST_GEN_POLY_LOW;
      degree_reg = RST_CHECK_DEGREE;
      length_reg = RST_MESSAGE_LENGTH;
      mismatches = 0;
    endfunction

    function void set_config(logic [31:0] low, logic [5:0] deg, logic [5:0] len);
      poly_low   = low;
      degree_reg = deg;
      length_reg = len;
    endfunction

    // Degree and length are clamped into 1..MAX.
    function int unsigned check_bits();
      int unsigned r;
      r = degree_reg;
      if (r < 1) r = 1;
      if (r > MAX_R) r = MAX_R;
      return r;
    endfunction

    function int unsigned message_bits();
      int unsigned k;
      k = length_reg;
      if (k < 1) k = 1;
      if (k > MAX_K) k = MAX_K;
      return k;
    endfunction

    function logic [63:0] width_mask(int unsigned bits);
      if (bits >= 64) return '1;
      return (64'd1 << bits) - 64'd1;
    endfunction

    // XOR long division of an n-bit word by x^r + low coefficients.
    function logic [63:0] gf2_remainder(logic [63:0] word, int unsigned n, int unsigned r);
      logic [63:0] gen;
      int unsigned b;
      gen = (64'd1 << r) | ({32'd0, poly_low} & width_mask(r));
      for (int unsigned i = n; i > r; i--) begin
        b = i - 1;
        if (word[b]) word ^= gen << (b - r);
      end
      return word & width_mask(r);
    endfunction

    function cce_out_t code_outcome(cce_in_t item);
      cce_out_t    res;
      int unsigned r, k, n;
      logic [63:0] nmask, word, rem, err;
      r     = check_bits();
      k     = message_bits();
      n     = r + k;
      nmask = width_mask(n);
      if (item.opcode == OP_ENCODE) begin
        word = (item.data_word & width_mask(k)) << r;
        rem  = gf2_remainder(word, n, r);
        res.code_word        = (word | rem) & nmask;
        res.syndrome         = rem[31:0];
        res.error_detected   = 1'b0;
        res.undetected_error = 1'b0;
      end else begin
        err  = item.error_pattern & nmask;
        word = (item.data_word & nmask) ^ err;
        rem  = gf2_remainder(word, n, r);
        res.code_word        = word;
        res.syndrome         = rem[31:0];
        res.error_detected   = (rem != 64'd0);
        res.undetected_error = (err != 64'd0) && (rem == 64'd0);
      end
      return res;
    endfunction

    function void note_input(cce_in_t item);
      outcome_q.push_back(code_outcome(item));
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    function void check_result(cce_out_t got);
      cce_out_t exp;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing outstanding: code_word %h syndrome %h",
                   $realtime, got.code_word, got.syndrome);
        return;
      end
      exp = outcome_q.pop_front();
      if (got.code_word !== exp.code_word || got.syndrome !== exp.syndrome ||
          got.error_detected !== exp.error_detected ||
          got.undetected_error !== exp.undetected_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: code_word exp %h got %h, syndrome exp %h got %h, %s",
                   $realtime, exp.code_word, got.code_word, exp.syndrome, got.syndrome,
                   $sformatf("detected exp %b got %b, undetected exp %b got %b",
                             exp.error_detected, got.error_detected,
                             exp.undetected_error, got.undetected_error));
      end
    endfunction

    // Whatever is still outstanding after a drain counts as lost.
    function void flag_leftover();
      if (outcome_q.size() != 0) begin
        if (mismatches < 10)
          $display("[%0t] %0d results never arrived", $realtime, outcome_q.size());
        mismatches += outcome_q.size();
        outcome_q.delete();
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [POLY_W-1:0]    cfg_data;

  cce_stream_if #(.payload_t(cce_in_t))  in_if ();
  cce_stream_if #(.payload_t(cce_out_t)) out_if ();

  cyclic_code_encode_and_check #(
    .MAX_CHECK_BITS  (MAX_R),
    .MAX_MESSAGE_BITS(MAX_K)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  codeword_scoreboard sb;

  // Idle rates in percent for each side; the main sequence changes them.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // A nonzero value asks the result side for one long hold-off.
  int unsigned hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Limit on the whole run, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: sets ready once per cycle, at random or held low for a long
  // stretch when asked, and hands every accepted result to the scoreboard.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.payload);
    end
  end

  function automatic cce_in_t pack_item(logic op, logic [63:0] data, logic [63:0] err);
    cce_in_t item;
    item.opcode        = op;
    item.data_word     = data;
    item.error_pattern = err;
    return item;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random item. Most check items carry a valid codeword, so that clean
  // words, correctable-looking errors, bursts and errors that are themselves
  // codewords (and slip through) all show up; the rest is plain noise.
  function automatic cce_in_t draw_item();
    int unsigned r, k, n, kind, len, pos;
    logic [63:0] nmask, cw, err, data, burst;
    r     = sb.check_bits();
    k     = sb.message_bits();
    n     = r + k;
    nmask = sb.width_mask(n);
    kind  = $urandom_range(0, 99);
    if (kind < 30)
      return pack_item(OP_ENCODE, ($urandom_range(0, 49) == 0) ? '1 : rand64(), rand64());
    if (kind >= 88)
      return pack_item(OP_CHECK, ($urandom_range(0, 9) == 0) ? '1 : rand64(),
                       ($urandom_range(0, 9) == 0) ? '1 : rand64());
    cw  = sb.code_outcome(pack_item(OP_ENCODE, rand64(), 64'd0)).code_word;
    err = 64'd0;
    if (kind < 45) begin
      // Clean codeword; sometimes with error bits only above the codeword.
      if ($urandom_range(0, 3) == 0) err = rand64() & ~nmask;
    end else if (kind < 65) begin
      repeat ($urandom_range(1, 3)) err[$urandom_range(0, n - 1)] = 1'b1;
    end else if (kind < 75) begin
      len   = $urandom_range(1, r);
      burst = (rand64() & sb.width_mask(len)) | 64'd1 | (64'd1 << (len - 1));
      pos   = $urandom_range(0, n - 1);
      err   = (burst << pos) & nmask;
    end else begin
      // Another codeword as error pattern: a multiple of the generator.
      err = sb.code_outcome(pack_item(OP_ENCODE, rand64(), 64'd0)).code_word;
    end
    data = cw;
    if ($urandom_range(0, 3) == 0) data |= rand64() & ~nmask;
    return pack_item(OP_CHECK, data, err);
  endfunction

  // Offers one item, idling at random first, and returns at the edge where
  // it is accepted. Valid stays high so back-to-back items need no gap.
  task automatic send_item(input cce_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(item);
  endtask

  // Stops offering items, waits until every result is in and then lets the
  // pipeline empty before the settings may change.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    sb.flag_leftover();
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called when idle.
  task automatic program_code(input logic [31:0] low, input logic [31:0] deg,
                              input logic [31:0] len);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_GEN_POLY_LOW;
    cfg_data <= low;
    @(posedge clk);
    cfg_idx  <= REG_CHECK_DEGREE;
    cfg_data <= deg;
    @(posedge clk);
    cfg_idx  <= REG_MESSAGE_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_config(low, deg[5:0], len[5:0]);
  endtask

  initial begin
    logic [31:0] low, deg, len;
    logic [63:0] cw_full, cw_top;
    sb            = new();
    send_idle_pct = 26;
    recv_idle_pct = 52;
    hold_request  = 0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_GEN_POLY_LOW;
    cfg_data      <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: g(x) = x^3 + x + 1, r = 3, k = 4,
    // which is the (7,4) Hamming code.
    cw_full = sb.code_outcome(pack_item(OP_ENCODE, 64'hF, 64'd0)).code_word;
    cw_top  = sb.code_outcome(pack_item(OP_ENCODE, 64'h8, 64'd0)).code_word;
    send_item(pack_item(OP_ENCODE, 64'd0, 64'd0));
    // Message bits above k are ignored, and so is the error pattern.
    send_item(pack_item(OP_ENCODE, '1, '1));
    send_item(pack_item(OP_ENCODE, 64'h1, 64'd0));
    send_item(pack_item(OP_ENCODE, 64'h8, 64'd0));
    send_item(pack_item(OP_CHECK, 64'd0, 64'd0));
    send_item(pack_item(OP_CHECK, cw_full, 64'd0));
    // Single errors at the lowest and highest codeword bit.
    send_item(pack_item(OP_CHECK, cw_top, 64'h01));
    send_item(pack_item(OP_CHECK, cw_top, 64'h40));
    // The generator itself as error pattern: passes as a valid word.
    send_item(pack_item(OP_CHECK, 64'd0, 64'h0B));
    // Both all ones: the masked words cancel, so the error goes unseen.
    send_item(pack_item(OP_CHECK, '1, '1));
    // Error bits only above the codeword are dropped, so no error at all.
    send_item(pack_item(OP_CHECK, cw_full | 64'hFFFF_FFFF_FFFF_FF80,
                        64'hFFFF_FFFF_FFFF_FF80));
    send_item(pack_item(OP_CHECK, rand64(), rand64()));
    drain();

    // Random phases, each under its own settings. The first three let the
    // sender idle less than the receiver, the next three the other way
    // round, and the last three run without idling.
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin low = 32'h07;       deg = 32'd8;  len = 32'd32; end
        1: begin low = 32'h04C1_1DB7; deg = 32'd32; len = 32'd32; end
        2: begin low = $urandom;     deg = 32'd1;  len = 32'd1;  end
        // Zero degree and length are raised to one.
        3: begin low = $urandom;     deg = 32'd0;  len = 32'd0;  end
        // Degree and length beyond the maximum are cut down to it.
        4: begin low = '1;           deg = 32'd63; len = 32'd40; end
        // Coefficient bits above r are ignored; bits above the register
        // width of degree and length are dropped.
        5: begin
          low = 32'h1021 | ($urandom & 32'hFFFF_0000);
          deg = 32'd16 | ($urandom & 32'hFFFF_FFC0);
          len = 32'd16 | ($urandom & 32'hFFFF_FFC0);
        end
        default: begin low = $urandom; deg = $urandom; len = $urandom; end
      endcase
      if (p < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 52;
      end else if (p < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_code(low, deg, len);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // Once, the receiver stops for a long stretch while items keep
        // coming, so the pipeline fills and input ready has to drop.
        if (p == 4 && i == 60) hold_request = 150;
        send_item(draw_item());
      end
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
